// File: design/mbta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbta_pkg;

   // Fixed field widths of the request and response words.
   localparam int unsigned TILE_W  = 23;
   localparam int unsigned SRC_W   = 24;
   // Tiled size in macroblocks, border included, and clamped sample index.
   localparam int unsigned DIM_W   = 9;
   localparam int unsigned POS_W   = 12;
   localparam int unsigned ROWTW_W = 17;
   localparam int unsigned PROD_W  = 26;

   localparam logic [TILE_W-1:0] TILE_MAX = {TILE_W{1'b1}};
   localparam logic [SRC_W-1:0]  SRC_MAX  = {SRC_W{1'b1}};

   // Source plane codes.
   localparam logic [1:0] PLANE_Y = 2'd0;
   localparam logic [1:0] PLANE_U = 2'd1;
   localparam logic [1:0] PLANE_V = 2'd2;

   // Register index on the configuration port (byte address / 4).
   typedef enum logic [2:0] {
      CSR_FRAME_STRIDE  = 3'd0,
      CSR_CHROMA_STRIDE = 3'd1,
      CSR_MB_COLUMNS    = 3'd2,
      CSR_MB_ROWS       = 3'd3,
      CSR_EDGE_EXPAND   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] tile_mb_col;
      logic [7:0] tile_mb_row;
      logic [7:0] byte_in_mb;
   } req_word_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile_offset;
      logic [1:0]        source_plane;
      logic [SRC_W-1:0]  source_offset;
      logic              position_error;
   } rsp_word_type;

   typedef struct packed {
      logic [13:0] frame_stride;
      logic [12:0] chroma_stride;
      logic [7:0]  mb_columns;
      logic [7:0]  mb_rows;
      logic        edge_expand;
   } cfg_type;

   // Output of the decode stage.
   typedef struct packed {
      logic             err;
      logic             chroma;
      logic [1:0]       plane;
      logic [7:0]       row;
      logic [7:0]       col;
      logic [DIM_W-1:0] tw;
      logic [7:0]       byte_idx;
      logic [POS_W-1:0] srow;
      logic [POS_W-1:0] scol;
      logic [13:0]      stride;
   } dec_type;

   // Output of the multiply stage.
   typedef struct packed {
      logic               err;
      logic               chroma;
      logic [1:0]         plane;
      logic [7:0]         col;
      logic [7:0]         byte_idx;
      logic [ROWTW_W-1:0] row_tw;
      logic [PROD_W-1:0]  src_prod;
      logic [POS_W-1:0]   scol;
   } mul_type;

endpackage

`default_nettype wire

// File: design/mbta_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module mbta_decode #(
   parameter int MAX_MB_COLS = 128,
   parameter int MAX_MB_ROWS = 128,
   parameter int BORDER_MBS  = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  mbta_pkg::req_word_type req,
   input  mbta_pkg::cfg_type      cfg,
   output logic                  dec_valid_ff,
   output mbta_pkg::dec_type      dec_ff
);
   import mbta_pkg::*;

   localparam logic [DIM_W-1:0] MAX_C = DIM_W'(MAX_MB_COLS);
   localparam logic [DIM_W-1:0] MAX_R = DIM_W'(MAX_MB_ROWS);
   localparam logic [DIM_W-1:0] BORD  = DIM_W'(BORDER_MBS);

   // Map a tiled macroblock index to a clamped sample index on one axis.
   function automatic logic [POS_W-1:0] clamp_axis(
      input logic [7:0]       idx,
      input logic [DIM_W-1:0] bdr,
      input logic [DIM_W-1:0] cnt,
      input logic             half,
      input logic [3:0]       sub_idx
   );
      logic [DIM_W-1:0] rel;
      logic [12:0]      span;
      logic [12:0]      base;
      rel  = {1'b0, idx} - bdr;
      span = half ? {1'b0, cnt, 3'b000} : {cnt, 4'b0000};
      base = half ? {1'b0, rel, 3'b000} : {rel, 4'b0000};
      if ({1'b0, idx} < bdr) begin
         clamp_axis = '0;
      end else if (rel >= cnt) begin
         clamp_axis = POS_W'(span - 13'd1);
      end else begin
         clamp_axis = POS_W'(base) + {8'd0, sub_idx};
      end
   endfunction

   logic [DIM_W-1:0] w;
   logic [DIM_W-1:0] h;
   logic [DIM_W-1:0] border;
   logic [DIM_W-1:0] tw;
   logic [DIM_W-1:0] th;
   logic [3:0]       x;
   logic             dec_valid_in;
   dec_type          dec_in;

   // Picture size, tiled size and range checks.
   always_comb begin
      w      = ({1'b0, cfg.mb_columns} > MAX_C) ? MAX_C : {1'b0, cfg.mb_columns};
      h      = ({1'b0, cfg.mb_rows} > MAX_R) ? MAX_R : {1'b0, cfg.mb_rows};
      border = cfg.edge_expand ? BORD : '0;
      tw     = w + {border[DIM_W-2:0], 1'b0};
      th     = h + {border[DIM_W-2:0], 1'b0};
      x      = req.req_type ? {1'b0, req.byte_in_mb[2:0]} : req.byte_in_mb[3:0];

      dec_in.err      = (w == '0) || (h == '0) ||
                        ({1'b0, req.tile_mb_col} >= tw) ||
                        ({1'b0, req.tile_mb_row} >= th) ||
                        (req.req_type && req.byte_in_mb[7]);
      dec_in.chroma   = req.req_type;
      dec_in.plane    = !req.req_type ? PLANE_Y :
                        (req.byte_in_mb[3] ? PLANE_V : PLANE_U);
      dec_in.row      = req.tile_mb_row;
      dec_in.col      = req.tile_mb_col;
      dec_in.tw       = tw;
      dec_in.byte_idx = req.byte_in_mb;
      dec_in.srow     = clamp_axis(req.tile_mb_row, border, h, req.req_type,
                                   req.byte_in_mb[7:4]);
      dec_in.scol     = clamp_axis(req.tile_mb_col, border, w, req.req_type, x);
      dec_in.stride   = req.req_type ? {1'b0, cfg.chroma_stride} : cfg.frame_stride;
      dec_valid_in    = in_valid;
   end

   // Stage valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= dec_valid_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
   end

endmodule

`default_nettype wire

// File: design/mbta_mult.sv
`timescale 1ns / 1ps
`default_nettype none

module mbta_mult (
   input  logic              clock,
   input  logic              reset,
   input  logic              dec_valid,
   input  mbta_pkg::dec_type dec,
   output logic              mul_valid_ff,
   output mbta_pkg::mul_type mul_ff
);
   import mbta_pkg::*;

   logic    mul_valid_in;
   mul_type mul_in;

   // Macroblock row base in the tiled plane and source row base.
   always_comb begin
      mul_in.err      = dec.err;
      mul_in.chroma   = dec.chroma;
      mul_in.plane    = dec.plane;
      mul_in.col      = dec.col;
      mul_in.byte_idx = dec.byte_idx;
      mul_in.row_tw   = {9'd0, dec.row} * {8'd0, dec.tw};
      mul_in.src_prod = {14'd0, dec.srow} * {12'd0, dec.stride};
      mul_in.scol     = dec.scol;
      mul_valid_in    = dec_valid;
   end

   // Stage valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
   end

endmodule

`default_nettype wire

// File: design/mbta_sum.sv
`timescale 1ns / 1ps
`default_nettype none

module mbta_sum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   mul_valid,
   input  mbta_pkg::mul_type      mul,
   output logic                   rsp_valid_ff,
   output mbta_pkg::rsp_word_type rsp_ff
);
   import mbta_pkg::*;

   logic [ROWTW_W-1:0] mb_idx;
   logic [24:0]        tile_full;
   logic [26:0]        src_full;
   logic               rsp_valid_in;
   rsp_word_type       rsp_in;

   // Final adds, saturation, and zeroing of rejected words.
   always_comb begin
      mb_idx    = mul.row_tw + {9'd0, mul.col};
      tile_full = mul.chroma ? ({1'b0, mb_idx, 7'd0} + {17'd0, mul.byte_idx})
                             : ({mb_idx, 8'd0} + {17'd0, mul.byte_idx});
      src_full  = {1'b0, mul.src_prod} + {15'd0, mul.scol};

      if (mul.err) begin
         rsp_in.tile_offset   = '0;
         rsp_in.source_plane  = PLANE_Y;
         rsp_in.source_offset = '0;
      end else begin
         rsp_in.tile_offset   = (|tile_full[24:23]) ? TILE_MAX : tile_full[22:0];
         rsp_in.source_plane  = mul.plane;
         rsp_in.source_offset = (|src_full[26:24]) ? SRC_MAX : src_full[23:0];
      end
      rsp_in.position_error = mul.err;
      rsp_valid_in          = mul_valid;
   end

   // Output strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output word.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// File: design/mb_tile_address_with_edge_clamp.sv
// A word accepted on start passes the decode, multiply and sum registers before rsp_valid.
// Throughput: one word per cycle; busy is never raised, since every stage
// advances each cycle (decode, then multiply, then sum and saturate).
// Reset: synchronous, active high; clears the stage valid bits and loads
// the register defaults. The receiver cannot stall the result strobe.
`timescale 1ns / 1ps
`default_nettype none

module mb_tile_address_with_edge_clamp #(
   parameter int MAX_MB_COLS = 128,
   parameter int MAX_MB_ROWS = 128,
   parameter int BORDER_MBS  = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mbta_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   output mbta_pkg::rsp_word_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [4:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import mbta_pkg::*;

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   csr_idx_type  csr_idx;
   logic         csr_write;
   logic         in_valid;
   logic         dec_valid;
   dec_type      dec;
   logic         mul_valid;
   mul_type      mul;

   assign busy     = 1'b0;
   assign pready   = 1'b1;
   assign in_valid = start && !busy;
   assign csr_idx  = csr_idx_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx)
            CSR_FRAME_STRIDE:  cfg_in.frame_stride  = pwdata[13:0];
            CSR_CHROMA_STRIDE: cfg_in.chroma_stride = pwdata[12:0];
            CSR_MB_COLUMNS:    cfg_in.mb_columns    = pwdata[7:0];
            CSR_MB_ROWS:       cfg_in.mb_rows       = pwdata[7:0];
            CSR_EDGE_EXPAND:   cfg_in.edge_expand   = pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_stride  <= 14'd1920;
         cfg_ff.chroma_stride <= 13'd960;
         cfg_ff.mb_columns    <= 8'd120;
         cfg_ff.mb_rows       <= 8'd68;
         cfg_ff.edge_expand   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_idx)
         CSR_FRAME_STRIDE:  prdata = {18'd0, cfg_ff.frame_stride};
         CSR_CHROMA_STRIDE: prdata = {19'd0, cfg_ff.chroma_stride};
         CSR_MB_COLUMNS:    prdata = {24'd0, cfg_ff.mb_columns};
         CSR_MB_ROWS:       prdata = {24'd0, cfg_ff.mb_rows};
         CSR_EDGE_EXPAND:   prdata = {31'd0, cfg_ff.edge_expand};
         default:           prdata = '0;
      endcase
   end

   // Pipeline stages.
   mbta_decode #(
      .MAX_MB_COLS (MAX_MB_COLS),
      .MAX_MB_ROWS (MAX_MB_ROWS),
      .BORDER_MBS  (BORDER_MBS)
   ) u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (in_valid),
      .req          (req_data),
      .cfg          (cfg_ff),
      .dec_valid_ff (dec_valid),
      .dec_ff       (dec)
   );

   mbta_mult u_mult (
      .clock        (clock),
      .reset        (reset),
      .dec_valid    (dec_valid),
      .dec          (dec),
      .mul_valid_ff (mul_valid),
      .mul_ff       (mul)
   );

   mbta_sum u_sum (
      .clock        (clock),
      .reset        (reset),
      .mul_valid    (mul_valid),
      .mul          (mul),
      .rsp_valid_ff (rsp_valid),
      .rsp_ff       (rsp_data)
   );

`ifndef SYNTH
   // Every result word matches a request word accepted on start.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result word without a matching request");

   // A rejected word carries zero offsets and plane.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.position_error) |->
         (rsp_data.tile_offset == '0 && rsp_data.source_offset == '0 &&
          rsp_data.source_plane == PLANE_Y))
      else $error("rejected word has nonzero fields");

   // The source plane is always one of Y, U or V.
   a_plane_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.source_plane != 2'd3))
      else $error("invalid source plane code");

   // A luma request that is not rejected yields a Y plane source.
   a_luma_plane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.position_error && $past(!req_data.req_type, 3)) |->
         (rsp_data.source_plane == PLANE_Y))
      else $error("luma request mapped to a chroma plane");
`endif

endmodule

`default_nettype wire

// File: tb/tile_address_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register ports of the tile address block,
// predicts every result word and compares it field by field.
module tile_address_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  mbta_pkg::req_word_type req_data,
   input  logic                   rsp_valid,
   input  mbta_pkg::rsp_word_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic                   pready,
   input  logic [4:0]             paddr,
   input  logic [31:0]            pwdata,
   output int                     words_in_flight,
   output int                     mismatch_count,
   output int                     checked_words,
   output int                     flagged_words
);
   import mbta_pkg::*;

   localparam longint unsigned MAX_COLS        = 128;
   localparam longint unsigned MAX_ROWS        = 128;
   localparam longint unsigned BORDER          = 2;
   localparam longint unsigned LUMA_MB_BYTES   = 256;
   localparam longint unsigned CHROMA_MB_BYTES = 128;
   localparam longint unsigned LUMA_SIDE       = 16;
   localparam longint unsigned CHROMA_SIDE     = 8;

   localparam cfg_type RESET_CFG = '{14'd1920, 13'd960, 8'd120, 8'd68, 1'b1};

   cfg_type      live_cfg;
   rsp_word_type expected_q[$];
   int           error_tally;
   int           check_tally;
   int           flag_tally;

   // Maps a tiled macroblock index to a raster sample index on one axis.
   // Border macroblocks fall back to the first or last picture sample.
   function automatic longint unsigned edge_sample(longint unsigned idx,
                                                   longint unsigned brd,
                                                   longint unsigned count,
                                                   longint unsigned side,
                                                   longint unsigned inner);
      if (idx < brd) begin
         return 0;
      end
      if (idx - brd >= count) begin
         return count * side - 1;
      end
      return (idx - brd) * side + inner;
   endfunction

   // Computes the tiled and raster addresses of one requested byte.
   function automatic rsp_word_type tile_address_for(cfg_type cfg, req_word_type rq);
      longint unsigned w, h, brd, tw, th, mb_bytes, tile;
      longint unsigned side, stride, inner, srow, scol, src;
      rsp_word_type r;
      r = '0;
      w   = (cfg.mb_columns > MAX_COLS) ? MAX_COLS : cfg.mb_columns;
      h   = (cfg.mb_rows > MAX_ROWS) ? MAX_ROWS : cfg.mb_rows;
      brd = cfg.edge_expand ? BORDER : 0;
      tw  = w + 2 * brd;
      th  = h + 2 * brd;

      // Rejected requests carry only the error flag.
      if (w == 0 || h == 0 || rq.tile_mb_col >= tw || rq.tile_mb_row >= th ||
          (rq.req_type && rq.byte_in_mb[7])) begin
         r.position_error = 1'b1;
         return r;
      end

      mb_bytes = rq.req_type ? CHROMA_MB_BYTES : LUMA_MB_BYTES;
      tile = (rq.tile_mb_row * tw + rq.tile_mb_col) * mb_bytes + rq.byte_in_mb;
      if (tile > TILE_MAX) begin
         tile = TILE_MAX;
      end

      // Chroma tiles interleave U in the left half and V in the right half.
      if (rq.req_type) begin
         side   = CHROMA_SIDE;
         stride = cfg.chroma_stride;
         inner  = rq.byte_in_mb[2:0];
         r.source_plane = rq.byte_in_mb[3] ? PLANE_V : PLANE_U;
      end else begin
         side   = LUMA_SIDE;
         stride = cfg.frame_stride;
         inner  = rq.byte_in_mb[3:0];
         r.source_plane = PLANE_Y;
      end

      srow = edge_sample(rq.tile_mb_row, brd, h, side, rq.byte_in_mb[7:4]);
      scol = edge_sample(rq.tile_mb_col, brd, w, side, inner);
      src  = srow * stride + scol;
      if (src > SRC_MAX) begin
         src = SRC_MAX;
      end

      r.tile_offset   = tile[TILE_W-1:0];
      r.source_offset = src[SRC_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_tally++;
   endtask

   // Track register writes, queue predictions and check result words.
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         live_cfg = RESET_CFG;
         expected_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               CSR_FRAME_STRIDE:  live_cfg.frame_stride  = pwdata[13:0];
               CSR_CHROMA_STRIDE: live_cfg.chroma_stride = pwdata[12:0];
               CSR_MB_COLUMNS:    live_cfg.mb_columns    = pwdata[7:0];
               CSR_MB_ROWS:       live_cfg.mb_rows       = pwdata[7:0];
               CSR_EDGE_EXPAND:   live_cfg.edge_expand   = pwdata[0];
               default: ;
            endcase
         end

         if (start && !busy) begin
            expected_q.push_back(tile_address_for(live_cfg, req_data));
         end

         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result word with no request waiting");
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.tile_offset !== want.tile_offset) begin
                  report_mismatch($sformatf("tile_offset %0d, expected %0d",
                                            rsp_data.tile_offset, want.tile_offset));
               end
               if (rsp_data.source_plane !== want.source_plane) begin
                  report_mismatch($sformatf("source_plane %0d, expected %0d",
                                            rsp_data.source_plane, want.source_plane));
               end
               if (rsp_data.source_offset !== want.source_offset) begin
                  report_mismatch($sformatf("source_offset %0d, expected %0d",
                                            rsp_data.source_offset, want.source_offset));
               end
               if (rsp_data.position_error !== want.position_error) begin
                  report_mismatch($sformatf("position_error %0b, expected %0b",
                                            rsp_data.position_error, want.position_error));
               end
               check_tally++;
               if (want.position_error) begin
                  flag_tally++;
               end
            end
         end
      end
      words_in_flight <= expected_q.size();
      mismatch_count  <= error_tally;
      checked_words   <= check_tally;
      flagged_words   <= flag_tally;
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Drives request words and register settings into the tile address block;
// the checker beside it predicts and compares the result words.
module tb_top;
   import mbta_pkg::*;

   localparam int RESET_CYCLES  = 6;
   localparam int LATENCY_SLACK = 6;
   localparam int IDLE_LIMIT    = 1000;
   localparam int NUM_PHASES    = 8;
   localparam int RANDOM_WORDS  = 185;
   localparam int EMPTY_WORDS   = 60;
   localparam int PRESSURE_PHASE = 4;

   localparam logic REQ_LUMA   = 1'b0;
   localparam logic REQ_CHROMA = 1'b1;
   // A register index with nothing behind it; writes there are dropped.
   localparam logic [2:0] CSR_UNMAPPED = 3'd5;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_data;
   logic         rsp_valid;
   rsp_word_type rsp_data;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [4:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   int      words_in_flight;
   int      mismatch_count;
   int      checked_words;
   int      flagged_words;
   int      words_sent;
   int      settings_used;
   int      idle_cycles;
   cfg_type plan;

   always #6 clock = ~clock;

   mb_tile_address_with_edge_clamp u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   tile_address_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .words_in_flight (words_in_flight),
      .mismatch_count  (mismatch_count),
      .checked_words   (checked_words),
      .flagged_words   (flagged_words)
   );

   // Present one request word and hold it until the block takes it.
   task automatic send_word(input req_word_type w);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted word has come back.
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the bus is released by the caller.
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic load_settings(input cfg_type c, input bit poke_unmapped);
      write_csr(CSR_FRAME_STRIDE, 32'(c.frame_stride));
      write_csr(CSR_CHROMA_STRIDE, 32'(c.chroma_stride));
      write_csr(CSR_MB_COLUMNS, 32'(c.mb_columns));
      write_csr(CSR_MB_ROWS, 32'(c.mb_rows));
      write_csr(CSR_EDGE_EXPAND, 32'(c.edge_expand));
      if (poke_unmapped) begin
         write_csr(CSR_UNMAPPED, 32'hFFFF_FFFF);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Register settings per phase: smallest, largest, oversized with
   // saturating strides, empty pictures, zero strides, then random ones.
   function automatic cfg_type phase_settings(input int p);
      cfg_type c;
      case (p)
         0: c = '{14'd16, 13'd8, 8'd1, 8'd1, 1'b0};
         1: c = '{14'd8192, 13'd4096, 8'd128, 8'd128, 1'b1};
         2: c = '{14'd16383, 13'd8191, 8'd255, 8'd200, 1'b1};
         3: c = '{14'd64, 13'd32, 8'd0, 8'd5, 1'b1};
         4: c = '{14'd100, 13'd50, 8'd7, 8'd0, 1'b0};
         5: c = '{14'd0, 13'd0, 8'd3, 8'd2, 1'b0};
         default: begin
            c.frame_stride  = 14'($urandom_range(16, 8192));
            c.chroma_stride = 13'($urandom_range(8, 4096));
            c.mb_columns    = 8'($urandom_range(1, 128));
            c.mb_rows       = 8'($urandom_range(1, 128));
            c.edge_expand   = 1'($urandom_range(0, 1));
         end
      endcase
      return c;
   endfunction

   function automatic logic [7:0] corner_byte();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd127;
         2: return 8'd128;
         default: return 8'd255;
      endcase
   endfunction

   function automatic logic [7:0] corner_index(input int extent);
      case ($urandom_range(0, 2))
         0: return 8'd0;
         1: return 8'(extent - 1);
         default: return 8'(extent);
      endcase
   endfunction

   // Mostly positions inside the tiled layout, some on its edges, the rest
   // fully random.
   function automatic req_word_type random_word(input cfg_type c);
      int tw, th, pick;
      req_word_type w;
      tw = ((c.mb_columns > 128) ? 128 : c.mb_columns) + (c.edge_expand ? 4 : 0);
      th = ((c.mb_rows > 128) ? 128 : c.mb_rows) + (c.edge_expand ? 4 : 0);
      w.req_type = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 80 && tw > 0 && th > 0) begin
         w.tile_mb_col = 8'($urandom_range(0, tw - 1));
         w.tile_mb_row = 8'($urandom_range(0, th - 1));
         w.byte_in_mb  = 8'(w.req_type ? $urandom_range(0, 127) : $urandom_range(0, 255));
      end else if (pick < 90) begin
         w.tile_mb_col = corner_index(tw);
         w.tile_mb_row = corner_index(th);
         w.byte_in_mb  = corner_byte();
      end else begin
         w.tile_mb_col = 8'($urandom);
         w.tile_mb_row = 8'($urandom);
         w.byte_in_mb  = 8'($urandom);
      end
      return w;
   endfunction

   // Stall watchdog: the run ends if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pwrite && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Stalled for %0d cycles with %0d words outstanding", IDLE_LIMIT,
                  words_in_flight);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int p, n, count, burst_left;
      words_sent    = 0;
      settings_used = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset settings (124 x 72 tiled macroblocks).
      settings_used = 1;
      send_word('{REQ_LUMA, 8'd0, 8'd0, 8'd0});
      send_word('{REQ_LUMA, 8'd0, 8'd0, 8'd255});
      send_word('{REQ_LUMA, 8'd2, 8'd2, 8'd0});
      send_word('{REQ_LUMA, 8'd121, 8'd69, 8'd255});
      send_word('{REQ_LUMA, 8'd123, 8'd71, 8'd255});
      send_word('{REQ_LUMA, 8'd124, 8'd0, 8'd0});
      send_word('{REQ_LUMA, 8'd0, 8'd72, 8'd0});
      send_word('{REQ_LUMA, 8'd255, 8'd255, 8'd255});
      send_word('{REQ_LUMA, 8'd60, 8'd30, 8'hA5});
      send_word('{REQ_CHROMA, 8'd0, 8'd0, 8'd0});
      send_word('{REQ_CHROMA, 8'd2, 8'd2, 8'd7});
      send_word('{REQ_CHROMA, 8'd2, 8'd2, 8'd8});
      send_word('{REQ_CHROMA, 8'd123, 8'd71, 8'd127});
      send_word('{REQ_CHROMA, 8'd5, 8'd5, 8'd128});
      send_word('{REQ_CHROMA, 8'd5, 8'd5, 8'd255});
      send_word('{REQ_CHROMA, 8'd124, 8'd71, 8'd0});
      send_word('{REQ_CHROMA, 8'd61, 8'd35, 8'h5A});
      send_word('{REQ_CHROMA, 8'd122, 8'd1, 8'h7F});

      // Random phases, each under its own register settings.
      for (p = 0; p < NUM_PHASES; p++) begin
         wait_for_results();
         plan = phase_settings(p);
         load_settings(plan, p == 2);
         settings_used++;
         count = (plan.mb_columns == 0 || plan.mb_rows == 0) ? EMPTY_WORDS : RANDOM_WORDS;
         burst_left = $urandom_range(1, 24);
         for (n = 0; n < count; n++) begin
            // Once, let the pipeline run completely dry mid-phase.
            if (p == PRESSURE_PHASE && n == count / 2) begin
               wait_for_results();
            end
            send_word(random_word(plan));
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 3) != 0) begin
                  pause_sender($urandom_range(1, 6));
               end
            end
         end
      end

      wait_for_results();
      $display("Sent %0d request words under %0d register settings, including empty,",
               words_sent, settings_used);
      $display("oversized and zero-stride pictures; %0d results checked, %0d rejected.",
               checked_words, flagged_words);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
